/* design/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes package
// s-box table, field multiply, round key and round functions shared by the core
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned KeyIdxW   = 1;

    localparam logic [KeyIdxW-1:0] RegKeyHigh = 1'd0;
    localparam logic [KeyIdxW-1:0] RegKeyLow  = 1'd1;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // byte n of the block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input t_block b, input int unsigned n);
        return b[127-8*n -: 8];
    endfunction

    // next round key from previous one and its round constant
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // subbytes, shiftrows, optional mixcolumns
    function automatic t_block round_fn(input t_block s, input logic mix);
        t_block t, o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(c*4+r) -: 8] = sbox(get_byte(s, ((c + r) % 4) * 4 + r));
            end
        end
        o = t;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, c*4);
                a1 = get_byte(t, c*4+1);
                a2 = get_byte(t, c*4+2);
                a3 = get_byte(t, c*4+3);
                al = a0 ^ a1 ^ a2 ^ a3;
                o[127-8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                o[127-8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                o[127-8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                o[127-8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* design/aes_keyexp.sv */
// ----------------------------------------------------------------------------
// aes key expansion
// holds the key registers and registers all eleven round keys
// ----------------------------------------------------------------------------
`default_nettype none

module aes_keyexp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [aes_pkg::KeyIdxW-1:0]  i_cfg_idx,
    input  wire logic [63:0]                  i_cfg_data,
    output logic [aes_pkg::NumRounds:0][127:0] o_rkey
);
    import aes_pkg::*;

    localparam logic [7:0] Rcon [NumRounds] =
        '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

    logic [63:0] r_key_hi, r_key_lo;
    t_block      r_rk [NumRounds+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegKeyHigh: r_key_hi <= i_cfg_data;
                RegKeyLow:  r_key_lo <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // one key step per register; a written key passes down the round key registers in order
    always_ff @(posedge i_clk) begin
        r_rk[0] <= {r_key_hi, r_key_lo};
        for (int i = 1; i <= NumRounds; i++) begin
            r_rk[i] <= next_key(r_rk[i-1], Rcon[i-1]);
        end
    end

    always_comb begin
        for (int i = 0; i <= NumRounds; i++) begin
            o_rkey[i] = r_rk[i];
        end
    end

endmodule

`default_nettype wire

/* design/aes_round.sv */
// ----------------------------------------------------------------------------
// aes round stage
// one registered round with valid and stall handling
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_mix,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rkey,
    output logic              o_valid,
    output logic [127:0]      o_state
);
    import aes_pkg::*;

    logic   r_valid;
    t_block r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= round_fn(i_state, i_mix) ^ i_rkey;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

/* design/aes128_block_encrypt_top.sv */
// ----------------------------------------------------------------------------
// aes-128 block encrypt top
// fully unrolled ecb encryption pipeline with stream ports
// ----------------------------------------------------------------------------
// one block enters per cycle while s_axis_tready is high; each ciphertext
// passes one input add-key stage and ten round stages. the whole
// pipeline advances only when the last stage is empty or taken, so a
// stall holds every item in place. the round keys are recomputed by a
// registered chain after a key write; the new key moves down that chain
// one stage per cycle, just ahead of the first item taken after the write.
// the input is held off while a key write is on the port, in the cycle
// after it and in the cycle after reset. write the key only while the
// pipeline is empty.
`default_nettype none

module aes128_block_encrypt_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [aes_pkg::KeyIdxW-1:0] i_cfg_idx,
    input  wire logic [63:0]                 i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [127:0]                s_axis_tdata,  // block_low, block_high
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [127:0]                     m_axis_tdata   // cipher_low, cipher_high
);
    import aes_pkg::*;

    logic [NumRounds:0][127:0] w_rkey;
    logic [NumRounds:0]        w_valid;
    t_block                    w_state [NumRounds+1];
    logic                      w_en;
    logic                      r_v0;
    t_block                    r_s0;
    logic                      r_key_wait;

    aes_keyexp u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rkey     (w_rkey)
    );

    // first round key register loads in the cycle after reset or a key write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_wait <= 1'b1;
        end else begin
            r_key_wait <= i_cfg_we;
        end
    end

    // pipeline advances when the output slot is free or drained
    assign w_en          = !w_valid[NumRounds] || m_axis_tready;
    assign s_axis_tready = w_en && !i_cfg_we && !r_key_wait;

    // initial add-key stage; tdata low half is block_high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ w_rkey[0];
        end
    end

    assign w_valid[0] = r_v0;
    assign w_state[0] = r_s0;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mix   (g != NumRounds),
            .i_en    (w_en),
            .i_valid (w_valid[g-1]),
            .i_state (w_state[g-1]),
            .i_rkey  (w_rkey[g]),
            .o_valid (w_valid[g]),
            .o_state (w_state[g])
        );
    end

    assign m_axis_tvalid = w_valid[NumRounds];
    assign m_axis_tdata  = {w_state[NumRounds][63:0], w_state[NumRounds][127:64]};

    // stalled output keeps its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");
    // accepted item reaches the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_valid[0])
        else $error("accepted item lost");
    // stall freezes the first stage
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid[0]) && $stable(r_s0))
        else $error("pipeline moved under stall");

endmodule

`default_nettype wire

/* sim/aes128_block_encrypt_top_tb.sv */
// ----------------------------------------------------------------------------
// aes-128 block encrypt testbench
// drives plaintext blocks under a series of keys through the stream ports and
// checks every ciphertext against an in-bench aes-128 encryptor
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int unsigned PipeLatency  = 11;
    localparam int unsigned SettleCycles = 16;   // latency plus margin around a key write
    localparam int unsigned StallLimit   = 5000; // cycles with no item moved on either side
    localparam int unsigned RandItems    = 1100;
    localparam int unsigned KeyPhases    = 8;
    localparam int unsigned QuietTail    = 120;  // last items run with no idling
    localparam int unsigned MaxReported  = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [KeyIdxW-1:0]   i_cfg_idx = RegKeyHigh;
    logic [63:0]          i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata = '0;   // block_low, block_high
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [127:0]         m_axis_tdata;        // cipher_low, cipher_high

    aes128_block_encrypt_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // encryptor model: s-box derived from the field inverse and affine map
    // ------------------------------------------------------------------------
    logic [7:0]   subst [256];
    logic [127:0] cur_key = '0;       // key as seen by the block
    logic [127:0] cipher_q [$];       // ciphertexts still to come out
    int unsigned  n_errors = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_keys = 0;
    bit           quiet = 1'b0;       // no idling on either side

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    initial begin
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            if (x == 0) inv = 8'h00;
            else for (int e = 0; e < 254; e++) inv = gmul(inv, x[7:0]);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            subst[x] = s;
        end
    end

    // byte n of a 128-bit value sits in bits 127-8n down
    function automatic logic [127:0] aes_encrypt(input logic [127:0] k,
                                                 input logic [127:0] p);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] t  [4];
        logic [7:0] f, rc, a0, a1, a2, a3, al;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = k[127-8*i -: 8];
            st[i] = p[127-8*i -: 8];
        end
        // key schedule, one 32-bit word at a time
        for (int w = 4; w < 44; w++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[(w-1)*4+j];
            if (w % 4 == 0) begin
                f = t[0];
                t[0] = subst[t[1]] ^ rc;
                t[1] = subst[t[2]];
                t[2] = subst[t[3]];
                t[3] = subst[f];
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++) rk[w*4+j] = rk[(w-4)*4+j] ^ t[j];
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        for (int r = 1; r <= 10; r++) begin
            // subbytes with shiftrows: row r of column c comes from column c+r
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    sh[c*4+w] = subst[st[((c+w)%4)*4+w]];
            for (int c = 0; c < 4; c++) begin
                a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
                if (r < 10) begin
                    al = a0 ^ a1 ^ a2 ^ a3;
                    sh[c*4]   = a0 ^ al ^ dbl(a0 ^ a1);
                    sh[c*4+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    sh[c*4+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    sh[c*4+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[r*16+i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // hold one item on the bus until it is taken, then queue its ciphertext
    // tdata carries block_high in the low half
    task automatic send_block(input logic [127:0] blk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_q.push_back(aes_encrypt(cur_key, blk));
    endtask

    // optional random gap after an item
    task automatic sender_gap();
        int unsigned n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every ciphertext is out and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // key write: only with the pipe empty, then let the round keys settle
    task automatic load_key(input logic [127:0] k);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= RegKeyHigh;
        i_cfg_data <= k[127:64];
        @(posedge i_clk);
        i_cfg_idx  <= RegKeyLow;
        i_cfg_data <= k[63:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_key = k;
        n_keys++;
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [127:0] rand_word();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // mostly random blocks, some with long runs of ones or zeros
    function automatic logic [127:0] pick_block();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return rand_word() & rand_word();
            3:       return rand_word() | rand_word();
            default: return rand_word();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // directed table: key, plaintext and, where obvious, the ciphertext
    // ------------------------------------------------------------------------
    typedef struct {
        logic [127:0] key;
        logic [127:0] blk;
        bit           known;
        logic [127:0] cipher;
    } t_vec;

    localparam logic [127:0] SpecKey = 128'h000102030405060708090a0b0c0d0e0f;

    t_vec vectors [] = '{
        // before any key write the zero key is in use
        '{128'h0, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{128'h0, '1,     1'b0, 128'h0},
        '{128'h0, 128'h80000000000000000000000000000000, 1'b0, 128'h0},
        '{128'h0, 128'h00000000000000000000000000000001, 1'b0, 128'h0},
        '{128'h0, 128'h0000000000000000ffffffffffffffff, 1'b0, 128'h0},
        // the standard worked example
        '{SpecKey, 128'h00112233445566778899aabbccddeeff, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{SpecKey, 128'h0, 1'b0, 128'h0},
        '{SpecKey, '1,     1'b0, 128'h0},
        // all-ones key
        '{'1, 128'h0, 1'b0, 128'h0},
        '{'1, '1,     1'b0, 128'h0},
        '{'1, 128'hffffffffffffffff0000000000000000, 1'b0, 128'h0},
        // each key half alone, then the top and bottom key bits
        '{128'hffffffffffffffff0000000000000000, 128'h0, 1'b0, 128'h0},
        '{128'h0000000000000000ffffffffffffffff, 128'h0, 1'b0, 128'h0},
        '{128'h80000000000000000000000000000001, '1,     1'b0, 128'h0}
    };

    // ------------------------------------------------------------------------
    // receiver side: random stalls, checking and the watchdog
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MaxReported)
                        $display("unexpected ciphertext %h", m_axis_tdata);
                end else begin
                    want = cipher_q.pop_front();
                    n_checked++;
                    // tdata carries cipher_high in the low half
                    if (m_axis_tdata[63:0] !== want[127:64]
                        || m_axis_tdata[127:64] !== want[63:0]) begin
                        n_errors++;
                        if (n_errors <= MaxReported)
                            $display("cipher mismatch: high exp %h got %h, low exp %h got %h",
                                     want[127:64], m_axis_tdata[63:0],
                                     want[63:0], m_axis_tdata[127:64]);
                    end
                end
            end

            // stall bursts on the result side
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= (stall_left == 1);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end

            // no item moved on either side for too long
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= StallLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [127:0] k;
        int unsigned  per_phase;
        int unsigned  sent;
        sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SettleCycles) @(posedge i_clk);

        // directed rows, key reloaded whenever a row names a new one
        foreach (vectors[i]) begin
            if (vectors[i].key !== cur_key) load_key(vectors[i].key);
            send_block(vectors[i].blk);
            // typed-in ciphertexts must agree with the in-bench encryptor
            if (vectors[i].known && cipher_q[$] !== vectors[i].cipher) begin
                n_errors++;
                if (n_errors <= MaxReported)
                    $display("encryptor disagrees on row %0d: exp %h got %h",
                             i, vectors[i].cipher, cipher_q[$]);
            end
            sender_gap();
        end

        // random part, a fresh key per phase with the extremes among them
        per_phase = RandItems / KeyPhases;
        for (int ph = 0; ph < KeyPhases; ph++) begin
            case (ph)
                0:       k = '0;
                1:       k = '1;
                2:       k = rand_word() & rand_word();
                default: k = rand_word();
            endcase
            load_key(k);
            for (int n = 0; n < per_phase; n++) begin
                if (sent >= RandItems - QuietTail) quiet = 1'b1;
                send_block(pick_block());
                sent++;
                // one full pause mid-phase, no key change
                if (ph == 3 && n == per_phase / 2) drain();
                else sender_gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        fork
            while (cipher_q.size() != 0) @(posedge i_clk);
            begin
                repeat (StallLimit) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (PipeLatency + 5) @(posedge i_clk);

        $display("encrypted %0d blocks under %0d keys, zero key, all-ones key and random keys",
                 n_checked, n_keys + 1);
        $display("ciphertexts checked %0d, errors %0d", n_checked, n_errors);
        if (n_errors == 0 && cipher_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/aes_pkg.sv
design/aes_keyexp.sv
design/aes_round.sv
design/aes128_block_encrypt_top.sv
sim/aes128_block_encrypt_top_tb.sv
